// File: src/bmf_pkg.sv
// ----------------------------------------------------------------------------
// bmf_pkg: shared types for the block median filter
// Sample type and the link record handed from one sorting cell to the next.
// ----------------------------------------------------------------------------
package bmf_pkg;

    localparam int SAMPLE_W = 12;

    typedef logic [SAMPLE_W-1:0] t_sample;

    // What a cell shows its right-hand neighbor: its stored value and whether
    // that value is occupied and greater than the incoming sample.
    typedef struct packed {
        logic    gt;
        t_sample val;
    } t_link;

endpackage

// File: src/block_median_filter_core.sv
// ----------------------------------------------------------------------------
// block_median_filter_core: median of non-overlapping blocks of samples
// Inserts each sample into a sorted chain of cells and gives one median at
// the end of every block of WINDOW samples.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                  Payload
//  input     in         i_in_valid / o_in_stall    i_sample [11:0]
//  output    out        o_out_valid / i_out_stall  o_median [11:0]
//
// Unless stalled, one sample is accepted per cycle; the whole chain shifts in that cycle.
// The median is registered in the cycle after the block's last sample.
// Input stalls only when the output register is full and stalled.
// Reset clears the fill count and the output valid; cell contents are
// not reset and are only read once written in the current block.
// ----------------------------------------------------------------------------
module block_median_filter_core
    import bmf_pkg::*;
#(
    parameter int WINDOW = 8
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_sample i_sample,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_sample o_median
);

    localparam int CW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam logic [CW-1:0] LAST = CW'(WINDOW - 1);

    logic [CW-1:0] r_fill;
    logic          r_out_valid;
    t_sample       r_median;
    t_sample       n_median;
    logic          accept;
    logic          last;

    t_link   link [WINDOW+1];
    t_sample nxt  [WINDOW];

    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;
    assign last       = (r_fill == LAST);

    assign link[0] = '{gt: 1'b0, val: '0};

    for (genvar g = 0; g < WINDOW; g++) begin : g_cell
        logic occupied;
        assign occupied = ({1'b0, r_fill} > (CW+1)'(g));

        bmf_cell u_cell (
            .i_clk      (i_clk),
            .i_load     (accept),
            .i_occupied (occupied),
            .i_sample   (i_sample),
            .i_left     (link[g]),
            .o_right    (link[g+1]),
            .o_next     (nxt[g])
        );
    end

    if ((WINDOW % 2) == 0) begin : g_even
        logic [SAMPLE_W:0] sum;
        assign sum      = {1'b0, nxt[WINDOW/2-1]} + {1'b0, nxt[WINDOW/2]};
        assign n_median = sum[SAMPLE_W:1];
    end else begin : g_odd
        assign n_median = nxt[WINDOW/2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_fill <= last ? '0 : r_fill + 1'b1;
            end
            if (accept && last) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && last) begin
            r_median <= n_median;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_median    = r_median;

endmodule

// File: src/bmf_cell.sv
// ----------------------------------------------------------------------------
// bmf_cell: one slot of the insertion sorting chain
// Holds one sample; on a load it keeps it, takes its left neighbor's value,
// or takes the new sample, so that the chain stays in ascending order.
// ----------------------------------------------------------------------------
module bmf_cell
    import bmf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_load,
    input  logic    i_occupied,
    input  t_sample i_sample,
    input  t_link   i_left,
    output t_link   o_right,
    output t_sample o_next
);

    t_sample r_val;
    t_sample n_val;
    logic    own_gt;

    assign own_gt = i_occupied && (r_val > i_sample);

    // An occupied cell not above the sample keeps its value. Otherwise the
    // cell takes the left value when that is still above the sample, and the
    // sample itself when it lands here. Equal values stay ahead of the new one.
    always_comb begin
        if (i_occupied && !own_gt) begin
            n_val = r_val;
        end else if (i_left.gt) begin
            n_val = i_left.val;
        end else begin
            n_val = i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_val <= n_val;
        end
    end

    assign o_right.gt  = own_gt;
    assign o_right.val = r_val;
    assign o_next      = n_val;

endmodule

// File: src/bmf_checker.sv
// ----------------------------------------------------------------------------
// bmf_checker: port-level checks for the block median filter
// Watches the top level's handshakes and the timing of results.
// ----------------------------------------------------------------------------
module bmf_checker
    import bmf_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    i_in_valid,
    input logic    o_in_stall,
    input t_sample i_sample,
    input logic    o_out_valid,
    input logic    i_out_stall,
    input t_sample o_median
);

    // A stalled input transaction stays offered with the same sample.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_sample))
        else $error("sample changed or dropped while stalled");

    // A held result keeps its value until the transaction completes.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_median))
        else $error("median changed or dropped while stalled");

    // The input side stalls only behind a full, stalled output register.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a pending result");

    // A new result only follows an accepted sample.
    a_result_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && !o_in_stall))
        else $error("result appeared without an input transaction");

    // Reset empties the output register.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind block_median_filter_core bmf_checker u_bmf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_sample    (i_sample),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_median    (o_median)
);

// File: verif/block_median_filter_core_test.sv
// ----------------------------------------------------------------------------
// block_median_filter_core_test: self-checking bench for the block median core
// Drives 12-bit samples through the valid/stall input channel, keeps a sorted
// copy of each block, and checks every median against it or the directed table.
// ----------------------------------------------------------------------------
module block_median_filter_core_test
    import bmf_pkg::*;
();

    localparam int WINDOW_LEN = 8;
    localparam int RANDOM_SAMPLES = 650;
    localparam int REPORT_LIMIT = 10;
    localparam int DRAIN_CYCLES = 20;
    localparam int IDLE_PCT = 8;
    localparam int CALM_FIRST = 250;
    localparam int CALM_LAST = 400;

    typedef struct packed {
        t_sample sample;
        logic    has_exp;
        t_sample exp;
    } t_row;

    // Three whole blocks: all low, all high, and a descending block whose two
    // middle values are the extremes; the all-high sum needs the thirteenth bit.
    localparam int DIRECTED_LEN = 3 * WINDOW_LEN;
    localparam t_row DIRECTED [DIRECTED_LEN] = '{
        '{12'd0,    1'b0, 12'd0}, '{12'd0,    1'b0, 12'd0},
        '{12'd0,    1'b0, 12'd0}, '{12'd0,    1'b0, 12'd0},
        '{12'd0,    1'b0, 12'd0}, '{12'd0,    1'b0, 12'd0},
        '{12'd0,    1'b0, 12'd0}, '{12'd0,    1'b1, 12'd0},
        '{12'd4095, 1'b0, 12'd0}, '{12'd4095, 1'b0, 12'd0},
        '{12'd4095, 1'b0, 12'd0}, '{12'd4095, 1'b0, 12'd0},
        '{12'd4095, 1'b0, 12'd0}, '{12'd4095, 1'b0, 12'd0},
        '{12'd4095, 1'b0, 12'd0}, '{12'd4095, 1'b1, 12'd4095},
        '{12'd4095, 1'b0, 12'd0}, '{12'd4095, 1'b0, 12'd0},
        '{12'd4095, 1'b0, 12'd0}, '{12'd4095, 1'b0, 12'd0},
        '{12'd0,    1'b0, 12'd0}, '{12'd0,    1'b0, 12'd0},
        '{12'd0,    1'b0, 12'd0}, '{12'd0,    1'b1, 12'd2047}
    };

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    i_in_valid = 1'b0;
    logic    o_in_stall;
    t_sample i_sample = '0;
    logic    o_out_valid;
    logic    i_out_stall = 1'b0;
    t_sample o_median;

    t_sample block_sorted [WINDOW_LEN];
    int      block_fill = 0;
    t_sample median_q [$];
    int      mismatches = 0;
    int      samples_sent = 0;
    bit      calm = 1'b0;

    block_median_filter_core #(
        .WINDOW(WINDOW_LEN)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_sample(i_sample),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_median(o_median)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Inserts one sample into the sorted copy of the block; on the last
    // sample of a block it returns the median and empties the copy.
    function automatic void insert_and_median(input t_sample s, output logic done,
                                              output t_sample med);
        int pos;
        logic [SAMPLE_W:0] pair_sum;
        pos = block_fill;
        while (pos > 0 && block_sorted[pos-1] > s) begin
            block_sorted[pos] = block_sorted[pos-1];
            pos--;
        end
        block_sorted[pos] = s;
        block_fill++;
        done = 1'b0;
        med = '0;
        if (block_fill == WINDOW_LEN) begin
            block_fill = 0;
            done = 1'b1;
            if (WINDOW_LEN % 2 == 0) begin
                pair_sum = {1'b0, block_sorted[WINDOW_LEN/2-1]}
                         + {1'b0, block_sorted[WINDOW_LEN/2]};
                med = pair_sum[SAMPLE_W:1];
            end else begin
                med = block_sorted[WINDOW_LEN/2];
            end
        end
    endfunction

    // Mostly uniform samples, with clusters of repeated values and extremes
    // mixed in so that equal values meet inside a block.
    function automatic t_sample pick_sample();
        int mode;
        mode = $urandom_range(0, 9);
        case (mode)
            6, 7: begin
                case ($urandom_range(0, 4))
                    0: return 12'd0;
                    1: return 12'd4095;
                    2: return 12'd2048;
                    3: return 12'd2047;
                    default: return 12'd1;
                endcase
            end
            8: return t_sample'($urandom_range(1000, 1003));
            9: return $urandom_range(0, 1) ? 12'd4095 : 12'd0;
            default: return t_sample'($urandom_range(0, 4095));
        endcase
    endfunction

    task automatic send_sample(input t_sample s, input logic has_exp, input t_sample exp);
        logic    done;
        t_sample med;
        @(negedge i_clk);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample <= s;
        do @(posedge i_clk); while (o_in_stall);
        insert_and_median(s, done, med);
        if (done) begin
            median_q.push_back(has_exp ? exp : med);
        end
        samples_sent++;
        calm = (samples_sent >= CALM_FIRST && samples_sent < CALM_LAST);
    endtask

    always @(negedge i_clk) begin
        i_out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (median_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("unexpected median transaction: %0d", o_median);
                end
            end else begin
                if (o_median !== median_q[0]) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("median mismatch: expected %0d, actual %0d",
                                 median_q[0], o_median);
                    end
                end
                void'(median_q.pop_front());
            end
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[k]) begin
            send_sample(DIRECTED[k].sample, DIRECTED[k].has_exp, DIRECTED[k].exp);
        end
        repeat (RANDOM_SAMPLES) begin
            send_sample(pick_sample(), 1'b0, '0);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b0;

        while (median_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("PASS block_median_filter_core");
        end else begin
            $display("FAIL block_median_filter_core");
        end
        $finish;
    end

    initial begin
        #200000;
        $display("FAIL block_median_filter_core");
        $finish;
    end

endmodule

// File: filelist.f
src/bmf_pkg.sv
src/bmf_cell.sv
src/block_median_filter_core.sv
src/bmf_checker.sv
verif/block_median_filter_core_test.sv
